@@ rtl/best_fit_heap_allocator_assert.svh @@
// Assertion macros for the best-fit heap allocator.
// Define NO_ASSERTIONS to compile every use down to nothing.
`ifndef BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define BFHA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator assertion failed");
// Check that cons holds in the cycle after ante.
`define BFHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator assertion failed");
`else
`define BFHA_ASSERT_NOW(label, clk, rst, ante, cons)
`define BFHA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/bfha_pkg.sv @@
package bfha_pkg;

   localparam int WORD_W    = 16;
   localparam int REQ_W     = 16;
   localparam int NEED_W    = 17;
   localparam int OFFSET_W  = 12;

   localparam logic [WORD_W-1:0] PREV_ALLOC = 16'h0002;
   localparam logic [WORD_W-1:0] CUR_ALLOC  = 16'h0001;
   localparam logic [NEED_W-1:0] NEED_ROUND = 17'd23;      // header plus alignment slack
   localparam logic [NEED_W-1:0] NEED_MASK  = ~17'h0000F;
   localparam logic [WORD_W-1:0] MIN_SPLIT  = 16'd16;
   localparam int HDR_BYTES = 8;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_EV,
      ST_SPLIT_REM,
      ST_SPLIT_FOOT,
      ST_NEXT_RD,
      ST_NEXT_WR,
      ST_HDR,
      ST_DONE
   } bfha_state_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_CLEAR,
      WR_REM,
      WR_FOOT,
      WR_NEXT,
      WR_HDR
   } bfha_wr_sel_type;

   typedef struct packed {
      logic            load_req;
      logic            walk_rd;
      logic            walk_eval;
      logic            next_rd;
      bfha_wr_sel_type wr_sel;
      logic            load_rsp;
   } bfha_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic req_zero;
      logic pos_in_range;
      logic list_end;
      logic found;
      logic split;
      logic nxt_in_range;
      logic rsp_busy;
   } bfha_status_type;

endpackage

@@ rtl/best_fit_heap_allocator.sv @@
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_request_bytes[15:0]
// rsp     | out       | rsp_valid / rsp_ready | rsp_granted, rsp_payload_offset[11:0]
//
// A transaction takes an accept step, a read and an evaluate step per header, the end
// mark included, the update states (ST_SPLIT_REM, ST_SPLIT_FOOT, or ST_NEXT_RD and, if
// the next block is in the heap, ST_NEXT_WR; then ST_HDR) and a load of the result
// register. The walk alone grows with block count; a zero request skips walk and update.
// After reset the heap memory is initialized by a pass over all HEAP_BYTES/8 words
// (512 at the default size) during which req_ready stays low.
// A finished result waits in the output register; the next request is taken while
// it waits, and only loading the following result stalls on rsp_ready.
`include "best_fit_heap_allocator_assert.svh"

module best_fit_heap_allocator import bfha_pkg::*; #(
   parameter int HEAP_BYTES = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [REQ_W-1:0]    req_request_bytes,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_granted,
   output logic [OFFSET_W-1:0] rsp_payload_offset
);

   bfha_cmd_type    cmd;
   bfha_status_type status;

   // Sequence the walk, the block update and the result hand-off.
   bfha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the heap memory, the walk pointer, the best candidate and the result.
   bfha_dp #(
      .HEAP_BYTES (HEAP_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_request_bytes  (req_request_bytes),
      .cmd                (cmd),
      .status             (status),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_granted        (rsp_granted),
      .rsp_payload_offset (rsp_payload_offset)
   );

   // A granted payload sits right after an 8-byte aligned header.
   `BFHA_ASSERT_NOW(a_offset_aligned, clock, reset, rsp_valid && rsp_granted, rsp_payload_offset[2:0] == 3'b000)
   // A failed transaction reports offset zero.
   `BFHA_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && !rsp_granted, rsp_payload_offset == '0)
   // Never overwrite a result that has not been taken.
   `BFHA_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.load_rsp, !rsp_valid || rsp_ready)
   // A loaded result shows up on the port in the next cycle.
   `BFHA_ASSERT_NEXT(a_rsp_shown, clock, reset, cmd.load_rsp, rsp_valid)

endmodule

@@ rtl/bfha_ctrl.sv @@
module bfha_ctrl import bfha_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            rsp_ready,
   input  bfha_status_type status,
   output bfha_cmd_type    cmd
);

   bfha_state_type state_ff, state_in;
   bfha_state_type walk_exit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Where to go once the list walk has reached its end mark or left the heap.
   assign walk_exit = !status.found ? ST_DONE :
                      (status.split ? ST_SPLIT_REM : ST_NEXT_RD);

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.load_req  = 1'b0;
      cmd.walk_rd   = 1'b0;
      cmd.walk_eval = 1'b0;
      cmd.next_rd   = 1'b0;
      cmd.wr_sel    = WR_NONE;
      cmd.load_rsp  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.wr_sel = WR_CLEAR;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = status.req_zero ? ST_DONE : ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            if (status.pos_in_range) begin
               cmd.walk_rd = 1'b1;
               state_in    = ST_WALK_EV;
            end else begin
               state_in = walk_exit;
            end
         end
         ST_WALK_EV: begin
            if (status.list_end) begin
               state_in = walk_exit;
            end else begin
               cmd.walk_eval = 1'b1;
               state_in      = ST_WALK_RD;
            end
         end
         ST_SPLIT_REM: begin
            cmd.wr_sel = WR_REM;
            state_in   = ST_SPLIT_FOOT;
         end
         ST_SPLIT_FOOT: begin
            cmd.wr_sel = WR_FOOT;
            state_in   = ST_HDR;
         end
         ST_NEXT_RD: begin
            if (status.nxt_in_range) begin
               cmd.next_rd = 1'b1;
               state_in    = ST_NEXT_WR;
            end else begin
               state_in = ST_HDR;
            end
         end
         ST_NEXT_WR: begin
            cmd.wr_sel = WR_NEXT;
            state_in   = ST_HDR;
         end
         ST_HDR: begin
            cmd.wr_sel = WR_HDR;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!status.rsp_busy || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/bfha_dp.sv @@
module bfha_dp import bfha_pkg::*; #(
   parameter int HEAP_BYTES = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [REQ_W-1:0]    req_request_bytes,
   input  bfha_cmd_type        cmd,
   output bfha_status_type     status,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_granted,
   output logic [OFFSET_W-1:0] rsp_payload_offset
);

   localparam int HEAP_WORDS = HEAP_BYTES / 8;
   localparam int AW         = $clog2(HEAP_WORDS);
   localparam int POS_W      = $clog2(HEAP_BYTES + 65536);
   localparam int IW         = POS_W - 3;
   localparam logic [IW-1:0]     WORDS_LIM = IW'(HEAP_WORDS);
   localparam logic [AW-1:0]     CLR_LAST  = AW'(HEAP_WORDS - 1);
   localparam logic [AW-1:0]     HDR_IDX   = AW'(1);
   localparam logic [AW-1:0]     FOOT_IDX  = AW'(HEAP_WORDS - 2);
   localparam logic [WORD_W-1:0] INIT_SIZE = WORD_W'(HEAP_BYTES - 16);
   localparam logic [POS_W-1:0]  FIRST_POS = POS_W'(HDR_BYTES);

   logic [WORD_W-1:0] heap_mem [HEAP_WORDS];
   logic [WORD_W-1:0] rd_data_ff;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic              found_ff, found_in;
   logic [POS_W-1:0]  best_pos_ff, best_pos_in;
   logic [WORD_W-1:0] fit_size_ff, fit_size_in;
   logic [WORD_W-1:0] best_hdr_ff, best_hdr_in;
   logic [AW-1:0]     clr_ff;
   logic              rsp_valid_ff;
   logic              rsp_granted_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;

   logic [WORD_W-1:0] size_w;
   logic              take;
   logic [WORD_W-1:0] left_w;
   logic [POS_W-1:0]  rem_pos, foot_pos, nxt_pos;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata;

   function automatic logic in_heap(input logic [POS_W-1:0] p);
      return p[POS_W-1:3] < WORDS_LIM;
   endfunction

   // Decode the header just read and the chosen block.
   assign size_w   = {rd_data_ff[WORD_W-1:4], 4'b0000};
   assign left_w   = fit_size_ff - need_ff[WORD_W-1:0];
   assign rem_pos  = best_pos_ff + POS_W'(need_ff);
   assign nxt_pos  = best_pos_ff + POS_W'(fit_size_ff);
   assign foot_pos = nxt_pos - POS_W'(HDR_BYTES);
   assign take     = !rd_data_ff[0] && ({1'b0, size_w} >= need_ff) &&
                     (!found_ff || size_w < fit_size_ff);

   assign status.clr_last     = clr_ff == CLR_LAST;
   assign status.req_zero     = req_request_bytes == '0;
   assign status.pos_in_range = in_heap(pos_ff);
   assign status.list_end     = size_w == '0;
   assign status.found        = found_ff;
   assign status.split        = left_w >= MIN_SPLIT;
   assign status.nxt_in_range = in_heap(nxt_pos);
   assign status.rsp_busy     = rsp_valid_ff;

   always_comb begin
      pos_in       = pos_ff;
      need_in      = need_ff;
      found_in     = found_ff;
      best_pos_in  = best_pos_ff;
      fit_size_in  = fit_size_ff;
      best_hdr_in  = best_hdr_ff;
      if (cmd.load_req) begin
         need_in  = ({1'b0, req_request_bytes} + NEED_ROUND) & NEED_MASK;
         pos_in   = FIRST_POS;
         found_in = 1'b0;
      end else if (cmd.walk_eval) begin
         pos_in = pos_ff + POS_W'(size_w);
         if (take) begin
            found_in     = 1'b1;
            best_pos_in  = pos_ff;
            fit_size_in  = size_w;
            best_hdr_in  = rd_data_ff;
         end
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = best_pos_ff[AW+2:3];
      mem_wdata = '0;
      case (cmd.wr_sel)
         WR_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            if (clr_ff == HDR_IDX) begin
               mem_wdata = INIT_SIZE | PREV_ALLOC;
            end else if (clr_ff == FOOT_IDX) begin
               mem_wdata = INIT_SIZE;
            end
         end
         WR_REM: begin
            mem_we    = in_heap(rem_pos);
            mem_waddr = rem_pos[AW+2:3];
            mem_wdata = left_w | PREV_ALLOC;
         end
         WR_FOOT: begin
            mem_we    = in_heap(foot_pos);
            mem_waddr = foot_pos[AW+2:3];
            mem_wdata = left_w;
         end
         WR_NEXT: begin
            mem_we    = 1'b1;
            mem_waddr = nxt_pos[AW+2:3];
            mem_wdata = rd_data_ff | PREV_ALLOC;
         end
         WR_HDR: begin
            mem_we = 1'b1;
            if (status.split) begin
               mem_wdata = need_ff[WORD_W-1:0] | (best_hdr_ff & PREV_ALLOC) | CUR_ALLOC;
            end else begin
               mem_wdata = best_hdr_ff | CUR_ALLOC;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   assign mem_re    = cmd.walk_rd || cmd.next_rd;
   assign mem_raddr = cmd.next_rd ? nxt_pos[AW+2:3] : pos_ff[AW+2:3];

   always_ff @(posedge clock) begin
      if (mem_we) heap_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= heap_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      need_ff      <= need_in;
      best_pos_ff  <= best_pos_in;
      fit_size_ff  <= fit_size_in;
      best_hdr_ff  <= best_hdr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
         if (cmd.wr_sel == WR_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_granted_ff <= found_ff;
         rsp_offset_ff  <= found_ff ? OFFSET_W'(best_pos_ff + FIRST_POS) : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_payload_offset = rsp_offset_ff;

endmodule
